/* src/ipst_pkg.sv */
// Shared types and constants for the IPv4 prefix sorted table.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package ipst_pkg;

  typedef struct packed {
    logic        action;
    logic [7:0]  text_char;
    logic        last_char;
    logic [31:0] origin_asn;
    logic [7:0]  read_index;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  insert_status;
    logic [7:0]  position;
    logic [8:0]  stored_count;
    logic        read_valid;
    logic [31:0] entry_address;
    logic [7:0]  entry_prefix_length;
    logic [31:0] entry_asn;
  } out_item_t;

  localparam logic        ACT_CHAR = 1'b0;
  localparam logic        ACT_READ = 1'b1;
  localparam logic [1:0]  ST_INSERTED = 2'd0;
  localparam logic [1:0]  ST_UPDATED  = 2'd1;
  localparam logic [1:0]  ST_FULL     = 2'd2;
  localparam logic [1:0]  ST_IPV6     = 2'd3;
  localparam logic [7:0]  CH_DOT   = 8'h2E;
  localparam logic [7:0]  CH_SLASH = 8'h2F;
  localparam logic [7:0]  CH_COLON = 8'h3A;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_char;   // parse one character
    logic scan_start;  // begin the sorted search with the parsed key
    logic scan_step;   // read the next entry during the search
    logic shift_step;  // one read or write step of moving an entry up one place
    logic write_new;   // write the new entry at the found place
    logic write_asn;   // update the AS number of the matched entry
    logic read_start;  // issue a table read
    logic load_ins;    // capture an insert result
    logic load_read;   // capture a read result
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic ipv6;        // the finished text held a colon
    logic scan_done;   // search position found
    logic match;       // entry at the position has the same key
    logic full;        // no room for a new entry
    logic shift_done;  // all entries above the position moved
  } dp_stat_t;

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      v = c[3:0] + 4'd9;
    return v;
  endfunction

endpackage
`default_nettype wire

/* src/ipst_ram.sv */
// Generic single-port-write, single-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module ipst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* src/ipst_datapath.sv */
// Datapath: text parser, entry memory, search and shift pointers, result register.
// Depends on ipst_pkg and ipst_ram.
`timescale 1ns / 1ps
`default_nettype none
module ipst_datapath #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ipst_pkg::in_item_t  item,
  input  wire ipst_pkg::dp_cmd_t   cmd,
  output ipst_pkg::dp_stat_t       stat,
  output ipst_pkg::out_item_t      result
);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;

  // Parse registers.
  logic [2:0]  field_index;
  logic [7:0]  octet_acc;
  logic [31:0] addr_asm;
  logic [7:0]  len_acc;
  logic        saw_colon;

  // Latched key of the item being inserted.
  logic [31:0] key_addr;
  logic [7:0]  key_len;
  logic [31:0] key_asn;
  logic        key_ipv6;

  logic [CW-1:0] valid_count;
  logic [CW-1:0] pos;
  logic [CW-1:0] shift_ptr;
  logic          scan_pending;

  logic [71:0]   ram_wdata, ram_rdata;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic          ram_we;
  logic [7:0]    rd_index;
  logic          rd_ok;

  ipst_ram #(.WIDTH(72), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [3:0]  dv;
  logic [7:0]  acc_in;
  logic [7:0]  acc_mul;
  logic [31:0] addr_final;
  logic [4:0]  oct_shift;
  logic        is_dot, is_slash;

  always_comb begin
    dv       = ipst_pkg::digit_value(item.text_char);
    acc_in   = (field_index < 3'd4) ? octet_acc : len_acc;
    acc_mul  = {acc_in[4:0], 3'b000} + {acc_in[6:0], 1'b0} + {4'd0, dv};
    is_dot   = (field_index < 3'd3) && (item.text_char == ipst_pkg::CH_DOT);
    is_slash = (field_index == 3'd3) && (item.text_char == ipst_pkg::CH_SLASH);
    oct_shift = 5'd24 - {field_index[1:0], 3'b000};
  end

  // Address after the current character, with the open octet placed.
  always_comb begin
    addr_final = addr_asm;
    if (is_dot || is_slash)
      addr_final = addr_asm | ({24'd0, octet_acc} << oct_shift);
    else if (field_index < 3'd4)
      addr_final = addr_asm | ({24'd0, acc_mul} << oct_shift);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index <= '0;
      octet_acc   <= '0;
      addr_asm    <= '0;
      len_acc     <= '0;
      saw_colon   <= 1'b0;
    end else if (cmd.take_char) begin
      if (item.last_char) begin
        field_index <= '0;
        octet_acc   <= '0;
        addr_asm    <= '0;
        len_acc     <= '0;
        saw_colon   <= 1'b0;
      end else begin
        if (item.text_char == ipst_pkg::CH_COLON) saw_colon <= 1'b1;
        if (is_dot || is_slash) begin
          addr_asm    <= addr_final;
          octet_acc   <= '0;
          field_index <= is_slash ? 3'd4 : field_index + 3'd1;
        end else if (field_index < 3'd4) begin
          octet_acc <= acc_mul;
        end else begin
          len_acc <= acc_mul;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_char && item.last_char) begin
      key_addr <= addr_final;
      key_len  <= (field_index == 3'd4) ? acc_mul : len_acc;
      key_asn  <= item.origin_asn;
      key_ipv6 <= saw_colon || (item.text_char == ipst_pkg::CH_COLON);
    end
    if (cmd.read_start) rd_index <= item.read_index;
  end

  // Search reads entry pos each step; the registered data arrives in the next cycle.
  logic [31:0] e_addr;
  logic [7:0]  e_len;
  logic [31:0] e_asn;
  logic        e_less, e_equal, at_end;
  always_comb begin
    e_addr  = ram_rdata[71:40];
    e_len   = ram_rdata[39:32];
    e_asn   = ram_rdata[31:0];
    e_less  = (e_addr < key_addr) || (e_addr == key_addr && e_len < key_len);
    e_equal = (e_addr == key_addr) && (e_len == key_len);
    at_end  = (pos >= valid_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_count  <= '0;
      pos          <= '0;
      shift_ptr    <= '0;
      scan_pending <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        pos          <= '0;
        scan_pending <= 1'b0;
      end else if (cmd.scan_step) begin
        // The shift starts on a read cycle, so the pending flag is cleared.
        if (stat.scan_done) begin
          scan_pending <= 1'b0;
          shift_ptr    <= valid_count;
        end else if (scan_pending) begin
          pos          <= pos + 1'b1;
          scan_pending <= 1'b0;
        end else begin
          scan_pending <= 1'b1;
        end
      end else if (cmd.shift_step) begin
        scan_pending <= ~scan_pending;
        if (scan_pending) shift_ptr <= shift_ptr - 1'b1;
      end
      if (cmd.write_new) valid_count <= valid_count + 1'b1;
    end
  end

  always_comb begin
    stat.ipv6       = key_ipv6;
    stat.scan_done  = scan_pending && (at_end || !e_less);
    stat.match      = !at_end && e_equal;
    stat.full       = (valid_count >= CW'(TABLE_DEPTH));
    stat.shift_done = (shift_ptr <= pos);
  end

  // Memory port use: search, shift and table reads read; shift, insert and update write.
  logic [AW-1:0] sp_m1;
  always_comb begin
    sp_m1     = AW'(shift_ptr - 1'b1);
    ram_raddr = AW'(pos);
    ram_we    = 1'b0;
    ram_waddr = AW'(pos);
    ram_wdata = {key_addr, key_len, key_asn};
    if (cmd.read_start) ram_raddr = AW'(item.read_index);
    if (cmd.shift_step) begin
      ram_raddr = sp_m1;
      ram_waddr = AW'(shift_ptr);
      ram_we    = scan_pending;
      ram_wdata = ram_rdata;
    end
    if (cmd.write_new) ram_we = 1'b1;
    if (cmd.write_asn) begin
      ram_we    = 1'b1;
      ram_wdata = {e_addr, e_len, key_asn};
    end
  end

  always_comb rd_ok = (32'(rd_index) < 32'(valid_count)) &&
                      (32'(rd_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.load_read) begin
      result.result_kind   <= ipst_pkg::ACT_READ;
      result.insert_status <= ipst_pkg::ST_INSERTED;
      result.position      <= rd_index;
      result.stored_count  <= 9'(valid_count);
      result.read_valid    <= rd_ok;
      result.entry_address <= rd_ok ? e_addr : '0;
      result.entry_prefix_length <= rd_ok ? e_len : '0;
      result.entry_asn     <= rd_ok ? e_asn : '0;
    end else if (cmd.load_ins) begin
      result.result_kind <= ipst_pkg::ACT_CHAR;
      result.read_valid  <= 1'b0;
      result.stored_count <= 9'(valid_count + (cmd.write_new ? 1'b1 : 1'b0));
      if (key_ipv6) begin
        result.insert_status <= ipst_pkg::ST_IPV6;
        result.position      <= '0;
        result.entry_address <= '0;
        result.entry_prefix_length <= '0;
        result.entry_asn     <= '0;
      end else begin
        result.insert_status <= stat.match ? ipst_pkg::ST_UPDATED :
                                stat.full  ? ipst_pkg::ST_FULL : ipst_pkg::ST_INSERTED;
        result.position      <= 8'(pos);
        result.entry_address <= key_addr;
        result.entry_prefix_length <= key_len;
        result.entry_asn     <= key_asn;
      end
    end
  end

  a_no_full_insert: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_new && stat.full))
    else $error("insert into a full table");
  a_one_write: assert property (@(posedge clk) disable iff (rst)
    !(cmd.write_new && cmd.write_asn))
    else $error("new entry and update issued together");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    valid_count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");
endmodule
`default_nettype wire

/* src/ipst_ctrl.sv */
// Controller: sequences parse, search, shift, write and result hand-off.
// Depends on ipst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ipst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire ipst_pkg::in_item_t item,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire ipst_pkg::dp_stat_t stat,
  output ipst_pkg::dp_cmd_t       cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_SHIFT = 6'b000100,
    S_WRITE = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept, slot_free;

  always_comb begin
    slot_free = !out_valid || !out_stall;
    in_stall  = !(state == S_IDLE && slot_free);
    accept    = in_valid && !in_stall;
  end

  always_comb begin
    cmd = '0;
    state_next = state;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (item.action == ipst_pkg::ACT_READ) begin
            cmd.read_start = 1'b1;
            state_next = S_READ;
          end else begin
            cmd.take_char = 1'b1;
            if (item.last_char) begin
              cmd.scan_start = 1'b1;
              state_next = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if (stat.ipv6) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_step = 1'b1;
          if (stat.scan_done) begin
            if (stat.match || stat.full) state_next = S_DONE;
            else state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        if (stat.shift_done) state_next = S_WRITE;
        else cmd.shift_step = 1'b1;
      end
      S_WRITE: state_next = S_DONE;
      S_READ: begin
        if (slot_free) begin
          cmd.load_read = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load_ins = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IDLE;
          // Write and update happen in the cycle the result is captured, against a
          // stable position; the WRITE state lets the last shift land first.
          if (!stat.ipv6) begin
            cmd.write_new = !stat.match && !stat.full;
            cmd.write_asn = stat.match;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (rst)
    !(accept && state != S_IDLE))
    else $error("transaction accepted while busy");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && out_stall && (cmd.load_ins || cmd.load_read)))
    else $error("result overwritten while stalled");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_ins && cmd.load_read))
    else $error("two results captured at once");
endmodule
`default_nettype wire

/* src/ipv4_prefix_sorted_table_insert_top.sv */
// Top level of the IPv4 prefix sorted table.
// Depends on ipst_pkg, ipst_ctrl and ipst_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Takes prefix text one character per transaction and keeps a table of
// (address, prefix length, AS number) sorted by address then length. A
// character that is not the last is taken while the controller stays idle.
// On the last character the table is searched entry by entry through the
// single read port, then every entry above the insert place is moved up
// one place; the memory port sets the pace of both passes, which IPv6
// text and reads skip. No new transaction is taken until the result is
// captured and the output slot is free. No clearing pass is needed after
// reset.
module ipv4_prefix_sorted_table_insert_top #(
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire ipst_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output ipst_pkg::out_item_t      out_data
);
  ipst_pkg::dp_cmd_t  cmd;
  ipst_pkg::dp_stat_t stat;

  ipst_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .item(in_data),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .stat(stat), .cmd(cmd)
  );

  ipst_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst(rst), .item(in_data), .cmd(cmd), .stat(stat),
    .result(out_data)
  );
endmodule
`default_nettype wire
